/* rtl/mnps_pkg.sv */
// ----------------------------------------------------------------------------
// mnps_pkg
// Shared widths, command and priority codes, sequencer states and the
// control word handed to the slot unit.
// ----------------------------------------------------------------------------
package mnps_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned PrioW = 2;
  localparam int unsigned NoteW = 7;
  localparam int unsigned VelW  = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_CLEAR    = 2'd2
  } mnps_cmd_e;

  typedef enum logic [PrioW-1:0] {
    PRIO_LAST = 2'd0,
    PRIO_HIGH = 2'd1,
    PRIO_LOW  = 2'd2
  } mnps_prio_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_UPDATE = 2'd2,
    ST_DONE   = 2'd3
  } mnps_state_e;

  typedef struct packed {
    mnps_prio_e             prio;
    logic                   remove;
    logic [NoteW-1:0]       note;
    logic [VelW-1:0]        vel;
  } mnps_ctl_t;

endpackage

/* rtl/mnps_if.sv */
// ----------------------------------------------------------------------------
// mnps_if
// Valid/ready channels: event words in, result words out, and the
// priority mode register write.
// ----------------------------------------------------------------------------
interface mnps_evt_if;
  logic                       valid;
  logic                       ready;
  logic [mnps_pkg::CmdW-1:0]  cmd;
  logic [mnps_pkg::NoteW-1:0] note;
  logic [mnps_pkg::VelW-1:0]  velocity;

  modport source (output valid, cmd, note, velocity, input ready);
  modport sink   (input valid, cmd, note, velocity, output ready);
endinterface

interface mnps_res_if;
  logic                       valid;
  logic                       ready;
  logic                       active_changed;
  logic                       note_was_held;
  logic                       active_valid;
  logic [mnps_pkg::NoteW-1:0] active_note;
  logic [mnps_pkg::VelW-1:0]  active_velocity;

  modport source (output valid, active_changed, note_was_held, active_valid, active_note,
                  active_velocity, input ready);
  modport sink   (input valid, active_changed, note_was_held, active_valid, active_note,
                  active_velocity, output ready);
endinterface

interface mnps_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mnps_pkg::PrioW-1:0] priority_mode;

  modport source (output valid, priority_mode, input ready);
  modport sink   (input valid, priority_mode, output ready);
endinterface

/* rtl/mnps_entry_ram.sv */
// ----------------------------------------------------------------------------
// mnps_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mnps_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mnps_slot_unit.sv */
// ----------------------------------------------------------------------------
// mnps_slot_unit
// Shared per-slot unit: note match, entry rewrite with rank update, and
// priority compare against the best entry so far.
// ----------------------------------------------------------------------------
module mnps_slot_unit #(
  parameter int unsigned AW = 4
) (
  input  mnps_pkg::mnps_ctl_t         ctl_i,
  input  logic [AW-1:0]               idx_i,
  input  logic [AW-1:0]               k_i,
  input  logic [AW-1:0]               r_i,
  input  logic [AW-1:0]               ins_age_i,
  input  logic [mnps_pkg::NoteW-1:0]  rd_note_i,
  input  logic [mnps_pkg::VelW-1:0]   rd_vel_i,
  input  logic [AW-1:0]               rd_age_i,
  input  logic [mnps_pkg::NoteW-1:0]  last_note_i,
  input  logic [mnps_pkg::VelW-1:0]   last_vel_i,
  input  logic [AW-1:0]               last_age_i,
  input  logic                        best_vld_i,
  input  logic [mnps_pkg::NoteW-1:0]  best_note_i,
  input  logic [AW-1:0]               best_age_i,
  output logic                        match_o,
  output logic [mnps_pkg::NoteW-1:0]  wr_note_o,
  output logic [mnps_pkg::VelW-1:0]   wr_vel_o,
  output logic [AW-1:0]               wr_age_o,
  output logic                        better_o
);

  import mnps_pkg::*;

  logic [NoteW-1:0] src_note;
  logic [VelW-1:0]  src_vel;
  logic [AW-1:0]    src_age;
  logic             hit_k;
  logic             cmp;

  assign hit_k   = (idx_i == k_i);
  assign match_o = (rd_note_i == ctl_i.note);

  always_comb begin
    src_note = rd_note_i;
    src_vel  = rd_vel_i;
    src_age  = rd_age_i;
    if (ctl_i.remove && hit_k) begin
      src_note = last_note_i;
      src_vel  = last_vel_i;
      src_age  = last_age_i;
    end
    wr_note_o = src_note;
    wr_vel_o  = src_vel;
    wr_age_o  = (src_age > r_i) ? src_age - AW'(1) : src_age;
    if (!ctl_i.remove && hit_k) begin
      wr_note_o = ctl_i.note;
      wr_vel_o  = ctl_i.vel;
      wr_age_o  = ins_age_i;
    end
  end

  always_comb begin
    unique case (ctl_i.prio)
      PRIO_HIGH: cmp = (wr_note_o > best_note_i);
      PRIO_LOW:  cmp = (wr_note_o < best_note_i);
      default:   cmp = (wr_age_o > best_age_i);
    endcase
  end

  assign better_o = !best_vld_i || cmp;

endmodule

/* rtl/mono_note_priority_stack.sv */
// ----------------------------------------------------------------------------
// mono_note_priority_stack
// Monophonic note priority stack: held notes with velocity and age rank,
// active note picked as last pressed, highest or lowest.
//
//   channel  dir  payload                                        handshake
//   evt_i    in   cmd, note, velocity                            valid/ready
//   res_o    out  active_changed, note_was_held, active_valid,   valid/ready
//                 active_note, active_velocity
//   cfg_i    in   priority_mode                                  valid/ready
//
// An event runs a scan pass over the held slots for the match, the oldest and
// the last entry, then a read-modify-write pass that rewrites ranks and picks
// the active note, each one slot per cycle and each waiting for the read port
// to drain; the done state then loads the result and the idle state takes the
// next word. Clear, unknown and note-off of an unheld note skip the second pass.
// Reset clears the held count, active note and mode; entries are not cleared.
// The result register holds until taken; the next event is accepted while it
// waits, and the sequencer stalls at the end of that event if still unread.
// ----------------------------------------------------------------------------
module mono_note_priority_stack #(
  parameter int unsigned DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mnps_evt_if.sink        evt_i,
  mnps_res_if.source      res_o,
  mnps_cfg_if.sink        cfg_i
);

  import mnps_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = NoteW + VelW + AW;

  mnps_state_e      state_q, state_d;
  logic [PrioW-1:0] prio_q;
  mnps_cmd_e        cmd_q;
  logic [NoteW-1:0] note_q;
  logic [VelW-1:0]  vel_q;
  logic             prev_valid_q;
  logic [NoteW-1:0] prev_note_q;
  logic [CW-1:0]    count_q;
  logic [NoteW-1:0] cur_note_q;
  logic [VelW-1:0]  cur_vel_q;

  logic [CW-1:0]    iss_q;
  logic             pend_q;
  logic [AW-1:0]    pidx_q;

  logic             found_q;
  logic [AW-1:0]    slot_q;
  logic [AW-1:0]    mage_q;
  logic [AW-1:0]    oldest_q;
  logic [NoteW-1:0] last_note_q;
  logic [VelW-1:0]  last_vel_q;
  logic [AW-1:0]    last_age_q;

  logic [AW-1:0]    upd_k_q;
  logic [AW-1:0]    upd_r_q;
  logic [AW-1:0]    ins_age_q;
  logic             remove_q;
  logic [CW-1:0]    new_count_q;

  logic             best_vld_q;
  logic [NoteW-1:0] best_note_q;
  logic [VelW-1:0]  best_vel_q;
  logic [AW-1:0]    best_age_q;

  logic             res_valid_q;
  logic             res_changed_q;
  logic             res_held_q;
  logic             res_act_q;
  logic [NoteW-1:0] res_note_q;
  logic [VelW-1:0]  res_vel_q;

  logic             evt_acc;
  logic [CW-1:0]    limit;
  logic             rd_en;
  logic             pass_done;
  logic             mem_we;
  logic             res_load;
  logic             changed;
  logic             full;

  logic [DW-1:0]    rdata;
  logic [NoteW-1:0] rd_note;
  logic [VelW-1:0]  rd_vel;
  logic [AW-1:0]    rd_age;
  mnps_ctl_t        ctl;
  logic             match;
  logic [NoteW-1:0] wr_note;
  logic [VelW-1:0]  wr_vel;
  logic [AW-1:0]    wr_age;
  logic             better;

  assign cfg_i.ready = 1'b1;
  assign evt_acc     = evt_i.valid && evt_i.ready;
  assign full        = (count_q == CW'(DEPTH));

  assign limit     = (state_q == ST_SCAN) ? count_q : new_count_q;
  assign pass_done = (iss_q == limit) && !pend_q;

  // outputs of the sequencer
  always_comb begin
    evt_i.ready = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    res_load    = 1'b0;
    unique case (state_q)
      ST_IDLE:   evt_i.ready = 1'b1;
      ST_SCAN:   rd_en = (iss_q < limit);
      ST_UPDATE: begin
        rd_en  = (iss_q < limit);
        mem_we = pend_q;
      end
      ST_DONE:   res_load = !res_valid_q || res_o.ready;
      default:   ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (evt_acc) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (pass_done) begin
          if ((cmd_q == CMD_NOTE_ON) || ((cmd_q == CMD_NOTE_OFF) && found_q)) begin
            state_d = ST_UPDATE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_UPDATE: begin
        if (pass_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rd_note = rdata[DW-1 -: NoteW];
  assign rd_vel  = rdata[AW +: VelW];
  assign rd_age  = rdata[AW-1:0];

  assign ctl.prio   = mnps_prio_e'(prio_q);
  assign ctl.remove = remove_q;
  assign ctl.note   = note_q;
  assign ctl.vel    = vel_q;

  mnps_entry_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pidx_q),
    .wdata_i ({wr_note, wr_vel, wr_age}),
    .re_i    (rd_en),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (rdata)
  );

  mnps_slot_unit #(
    .AW (AW)
  ) u_unit (
    .ctl_i       (ctl),
    .idx_i       (pidx_q),
    .k_i         (upd_k_q),
    .r_i         (upd_r_q),
    .ins_age_i   (ins_age_q),
    .rd_note_i   (rd_note),
    .rd_vel_i    (rd_vel),
    .rd_age_i    (rd_age),
    .last_note_i (last_note_q),
    .last_vel_i  (last_vel_q),
    .last_age_i  (last_age_q),
    .best_vld_i  (best_vld_q),
    .best_note_i (best_note_q),
    .best_age_i  (best_age_q),
    .match_o     (match),
    .wr_note_o   (wr_note),
    .wr_vel_o    (wr_vel),
    .wr_age_o    (wr_age),
    .better_o    (better)
  );

  always_comb begin
    unique case (cmd_q)
      CMD_NOTE_ON:  changed = !prev_valid_q || (cur_note_q != prev_note_q);
      CMD_NOTE_OFF: changed = found_q && ((count_q == '0) || (cur_note_q != prev_note_q));
      CMD_CLEAR:    changed = prev_valid_q;
      default:      changed = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prio_q      <= PRIO_LAST;
      count_q     <= '0;
      cur_note_q  <= '0;
      cur_vel_q   <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      remove_q    <= 1'b0;
      new_count_q <= '0;
      best_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (cfg_i.valid && cfg_i.ready) begin
        prio_q <= cfg_i.priority_mode;
      end
      if (rd_en) begin
        iss_q <= iss_q + CW'(1);
      end
      if (evt_acc) begin
        iss_q   <= '0;
        found_q <= 1'b0;
      end
      if ((state_q == ST_SCAN) && pend_q && match && !found_q) begin
        found_q <= 1'b1;
      end
      if ((state_q == ST_SCAN) && pass_done) begin
        iss_q      <= '0;
        best_vld_q <= 1'b0;
        remove_q   <= (cmd_q == CMD_NOTE_OFF);
        if (cmd_q == CMD_NOTE_ON) begin
          new_count_q <= (found_q || full) ? count_q : count_q + CW'(1);
        end else begin
          new_count_q <= count_q - CW'(1);
        end
        if (cmd_q == CMD_CLEAR) begin
          count_q    <= '0;
          cur_note_q <= '0;
          cur_vel_q  <= '0;
        end
      end
      if ((state_q == ST_UPDATE) && pend_q && better) begin
        best_vld_q <= 1'b1;
      end
      if ((state_q == ST_UPDATE) && pass_done) begin
        count_q    <= new_count_q;
        cur_note_q <= best_vld_q ? best_note_q : '0;
        cur_vel_q  <= best_vld_q ? best_vel_q : '0;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      cmd_q        <= mnps_cmd_e'(evt_i.cmd);
      note_q       <= evt_i.note;
      vel_q        <= evt_i.velocity;
      prev_valid_q <= (count_q != '0);
      prev_note_q  <= cur_note_q;
    end
    if (rd_en) begin
      pidx_q <= iss_q[AW-1:0];
    end
    if ((state_q == ST_SCAN) && pend_q) begin
      if (match && !found_q) begin
        slot_q <= pidx_q;
        mage_q <= rd_age;
      end
      if (rd_age == '0) begin
        oldest_q <= pidx_q;
      end
      if (CW'(pidx_q) == count_q - CW'(1)) begin
        last_note_q <= rd_note;
        last_vel_q  <= rd_vel;
        last_age_q  <= rd_age;
      end
    end
    if ((state_q == ST_SCAN) && pass_done) begin
      if (cmd_q == CMD_NOTE_ON) begin
        if (found_q) begin
          upd_k_q   <= slot_q;
          upd_r_q   <= mage_q;
          ins_age_q <= AW'(count_q - CW'(1));
        end else if (full) begin
          upd_k_q   <= oldest_q;
          upd_r_q   <= '0;
          ins_age_q <= AW'(count_q - CW'(1));
        end else begin
          upd_k_q   <= AW'(count_q);
          upd_r_q   <= '1;
          ins_age_q <= AW'(count_q);
        end
      end else begin
        upd_k_q   <= slot_q;
        upd_r_q   <= mage_q;
        ins_age_q <= '0;
      end
    end
    if ((state_q == ST_UPDATE) && pend_q && better) begin
      best_note_q <= wr_note;
      best_vel_q  <= wr_vel;
      best_age_q  <= wr_age;
    end
    if (res_load) begin
      res_changed_q <= changed;
      res_held_q    <= found_q;
      res_act_q     <= (count_q != '0);
      res_note_q    <= cur_note_q;
      res_vel_q     <= cur_vel_q;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.active_changed  = res_changed_q;
  assign res_o.note_was_held   = res_held_q;
  assign res_o.active_valid    = res_act_q;
  assign res_o.active_note     = res_note_q;
  assign res_o.active_velocity = res_vel_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("held count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> ((cur_note_q == '0) && (cur_vel_q == '0)))
    else $error("active note left over with empty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(pidx_q) < new_count_q))
    else $error("entry write beyond held slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (cmd_q == CMD_CLEAR)) |-> (count_q == '0))
    else $error("clear left notes held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q)
    else $error("read still pending when idle");

endmodule
